/* rtl/positional_ordered_list_macros.svh */
// Assertion macros used by the positional list top level.
`ifndef POSITIONAL_ORDERED_LIST_MACROS_SVH
`define POSITIONAL_ORDERED_LIST_MACROS_SVH
`ifndef SYNTH
// Combinational check, sampled at every rising clock edge outside reset.
`define POL_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
// Implication check: when ante holds, cons holds at the next edge.
`define POL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define POL_ASSERT(lbl, expr, msg)
`define POL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/pol_pkg.sv */
// Package with sizes, codes and the control structs of the positional list.
`timescale 1ns / 1ps
package pol_pkg;
	localparam int CAPACITY = 16;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CMD_W = 3;
	localparam int POS_W = 5;
	localparam int VAL_W = 32;
	localparam int LEN_W = 5;
	localparam int ST_W = 2;
	// Compare width: holds a position, a count and either plus one.
	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	typedef logic [CMD_W-1:0] cmd_code_t;
	typedef logic [ST_W-1:0] status_t;

	localparam cmd_code_t CMD_INS_FRONT = 3'd0;
	localparam cmd_code_t CMD_INS_BACK = 3'd1;
	localparam cmd_code_t CMD_INS_AT = 3'd2;
	localparam cmd_code_t CMD_DEL_AT = 3'd3;
	localparam cmd_code_t CMD_DUMP = 3'd4;

	localparam status_t ST_OK = 2'd0;
	localparam status_t ST_RANGE = 2'd1;
	localparam status_t ST_FULL = 2'd2;
	localparam status_t ST_EMPTY = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic update;
		logic start_dump;
		logic dump_emit;
	} pol_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic dump_req;
		logic dump_last;
	} pol_stat_t;
endpackage

/* rtl/pol_ctrl.sv */
// Controller state machine: input/output handshakes and dump sequencing.
`timescale 1ns / 1ps
module pol_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  pol_pkg::pol_stat_t stat,
	output pol_pkg::pol_cmd_t  cmd
);
	localparam logic S_IDLE = 1'b0;
	localparam logic S_DUMP = 1'b1;

	logic state_q;
	logic state_nxt;
	logic out_valid_q;
	logic out_free;

	// The output register can take a word when empty or being drained now.
	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				in_ready = out_free;
				if (in_valid && out_free) begin
					if (stat.dump_req) begin
						cmd.start_dump = 1'b1;
						state_nxt = S_DUMP;
					end else begin
						cmd.update = 1'b1;
					end
				end
			end
			S_DUMP: begin
				if (out_free) begin
					cmd.dump_emit = 1'b1;
					if (stat.dump_last) begin
						state_nxt = S_IDLE;
					end
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.update || cmd.dump_emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

/* rtl/pol_dp.sv */
// Datapath: shifting list cells, element count, dump index and output register.
`timescale 1ns / 1ps
module pol_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [pol_pkg::CMD_W-1:0]         command,
	input  logic [pol_pkg::POS_W-1:0]         position,
	input  logic signed [pol_pkg::VAL_W-1:0]  value,
	input  pol_pkg::pol_cmd_t                 cmd,
	output pol_pkg::pol_stat_t                stat,
	output logic signed [pol_pkg::VAL_W-1:0]  value_res,
	output logic [pol_pkg::LEN_W-1:0]         position_res,
	output logic [pol_pkg::LEN_W-1:0]         length,
	output logic [pol_pkg::ST_W-1:0]          status,
	output logic                              last
);
	logic signed [pol_pkg::VAL_W-1:0] entries_q [pol_pkg::CAPACITY];
	logic signed [pol_pkg::VAL_W-1:0] entry_nxt [pol_pkg::CAPACITY];
	logic signed [pol_pkg::VAL_W-1:0] prev_w [pol_pkg::CAPACITY];
	logic signed [pol_pkg::VAL_W-1:0] next_w [pol_pkg::CAPACITY];
	logic [pol_pkg::CNT_W-1:0] count_q;
	logic [pol_pkg::CNT_W-1:0] cnt_nxt;
	logic [pol_pkg::IDX_W-1:0] idx_q;

	logic [pol_pkg::CMP_W-1:0] cnt_ext;
	logic [pol_pkg::CMP_W-1:0] pos_ext;
	logic [pol_pkg::CMP_W-1:0] cnt_nxt_ext;
	logic [pol_pkg::CMP_W-1:0] dump_pos;
	logic [pol_pkg::CMP_W-1:0] op_idx;
	logic full;
	logic empty;
	logic ins_ok;
	logic del_ok;
	pol_pkg::status_t upd_status;

	logic signed [pol_pkg::VAL_W-1:0] value_res_q;
	logic [pol_pkg::LEN_W-1:0] position_res_q;
	logic [pol_pkg::LEN_W-1:0] length_q;
	pol_pkg::status_t status_q;
	logic last_q;

	assign cnt_ext = pol_pkg::CMP_W'(count_q);
	assign pos_ext = pol_pkg::CMP_W'(position);
	assign full = (count_q >= pol_pkg::CNT_W'(pol_pkg::CAPACITY));
	assign empty = (count_q == '0);

	// Decode the update command: range before fullness, empty before range, as specified.
	always_comb begin
		ins_ok = 1'b0;
		del_ok = 1'b0;
		op_idx = '0;
		upd_status = pol_pkg::ST_OK;
		case (command)
			pol_pkg::CMD_INS_FRONT: begin
				if (full) begin
					upd_status = pol_pkg::ST_FULL;
				end else begin
					ins_ok = 1'b1;
				end
			end
			pol_pkg::CMD_INS_BACK: begin
				op_idx = cnt_ext;
				if (full) begin
					upd_status = pol_pkg::ST_FULL;
				end else begin
					ins_ok = 1'b1;
				end
			end
			pol_pkg::CMD_INS_AT: begin
				op_idx = pos_ext - pol_pkg::CMP_W'(1);
				if (pos_ext == '0 || pos_ext > cnt_ext + pol_pkg::CMP_W'(1)) begin
					upd_status = pol_pkg::ST_RANGE;
				end else if (full) begin
					upd_status = pol_pkg::ST_FULL;
				end else begin
					ins_ok = 1'b1;
				end
			end
			pol_pkg::CMD_DEL_AT: begin
				op_idx = pos_ext - pol_pkg::CMP_W'(1);
				if (empty) begin
					upd_status = pol_pkg::ST_EMPTY;
				end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
					upd_status = pol_pkg::ST_RANGE;
				end else begin
					del_ok = 1'b1;
				end
			end
			pol_pkg::CMD_DUMP: begin
				// Only an empty list takes the single-word path for a dump.
				upd_status = pol_pkg::ST_EMPTY;
			end
			default: begin
				upd_status = pol_pkg::ST_OK;
			end
		endcase
	end

	always_comb begin
		cnt_nxt = count_q;
		if (ins_ok) begin
			cnt_nxt = count_q + pol_pkg::CNT_W'(1);
		end else if (del_ok) begin
			cnt_nxt = count_q - pol_pkg::CNT_W'(1);
		end
	end
	assign cnt_nxt_ext = pol_pkg::CMP_W'(cnt_nxt);

	// Each cell picks its own value, its left neighbor, its right neighbor or the new word.
	for (genvar i = 0; i < pol_pkg::CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign prev_w[i] = entries_q[i];
		end else begin : g_prev
			assign prev_w[i] = entries_q[i-1];
		end
		if (i == pol_pkg::CAPACITY - 1) begin : g_end
			assign next_w[i] = entries_q[i];
		end else begin : g_next
			assign next_w[i] = entries_q[i+1];
		end
		always_comb begin
			entry_nxt[i] = entries_q[i];
			if (ins_ok) begin
				if (pol_pkg::CMP_W'(i) == op_idx) begin
					entry_nxt[i] = value;
				end else if (pol_pkg::CMP_W'(i) > op_idx) begin
					entry_nxt[i] = prev_w[i];
				end
			end else if (del_ok) begin
				if (pol_pkg::CMP_W'(i) >= op_idx) begin
					entry_nxt[i] = next_w[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			entries_q <= entry_nxt;
		end
	end

	assign dump_pos = pol_pkg::CMP_W'(idx_q) + pol_pkg::CMP_W'(1);
	assign stat.dump_req = (command == pol_pkg::CMD_DUMP) && !empty;
	assign stat.dump_last = (dump_pos == cnt_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q <= '0;
		end else begin
			if (cmd.update) begin
				count_q <= cnt_nxt;
			end
			if (cmd.start_dump) begin
				idx_q <= '0;
			end else if (cmd.dump_emit) begin
				idx_q <= idx_q + pol_pkg::IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			value_res_q <= '0;
			position_res_q <= '0;
			length_q <= cnt_nxt_ext[pol_pkg::LEN_W-1:0];
			status_q <= upd_status;
			last_q <= 1'b1;
		end else if (cmd.dump_emit) begin
			value_res_q <= entries_q[idx_q];
			position_res_q <= dump_pos[pol_pkg::LEN_W-1:0];
			length_q <= cnt_ext[pol_pkg::LEN_W-1:0];
			status_q <= pol_pkg::ST_OK;
			last_q <= stat.dump_last;
		end
	end

	assign value_res = value_res_q;
	assign position_res = position_res_q;
	assign length = length_q;
	assign status = status_q;
	assign last = last_q;
endmodule

/* rtl/positional_ordered_list.sv */
// Top level of the bounded positional list: controller, datapath and checks.
//
//  Channel  Handshake              Payload
//  in       in_valid / in_ready    command, position, value
//  out      out_valid / out_ready  value_res, position_res, length, status, last
//
// An update command yields one word; a new command is taken
// every cycle as long as the output register drains.
// A dump of N elements first takes the command, then loads one word per cycle from the list cells
// while the output register drains; in_ready stays low until its last word is loaded.
// Reset clears the element count and the control state; the cells hold no reset.
// A stall on out_ready holds the output word and blocks the next command.
`timescale 1ns / 1ps
`include "positional_ordered_list_macros.svh"
module positional_ordered_list (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [pol_pkg::CMD_W-1:0]         command,
	input  logic [pol_pkg::POS_W-1:0]         position,
	input  logic signed [pol_pkg::VAL_W-1:0]  value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [pol_pkg::VAL_W-1:0]  value_res,
	output logic [pol_pkg::LEN_W-1:0]         position_res,
	output logic [pol_pkg::LEN_W-1:0]         length,
	output logic [pol_pkg::ST_W-1:0]          status,
	output logic                              last
);
	pol_pkg::pol_cmd_t cmd;
	pol_pkg::pol_stat_t stat;

	pol_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pol_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.command     (command),
		.position    (position),
		.value       (value),
		.cmd         (cmd),
		.stat        (stat),
		.value_res   (value_res),
		.position_res(position_res),
		.length      (length),
		.status      (status),
		.last        (last)
	);

	// A word that is not the last one only comes from a dump in progress.
	`POL_ASSERT(a_mid_dump_blocks_input, !(out_valid && !last && in_ready), "input open mid dump")
	// Every accepted command other than a non-empty dump loads exactly one word.
	`POL_ASSERT_NEXT(a_update_gives_word, in_valid && in_ready && !stat.dump_req, out_valid, "no word")
	// Starting a dump closes the input until the dump is done.
	`POL_ASSERT_NEXT(a_dump_closes_input, in_valid && in_ready && stat.dump_req, !in_ready, "input open")
	// The controller never asks for an update and a dump word at once.
	`POL_ASSERT(a_one_action, !(cmd.update && cmd.dump_emit), "update and dump word together")
endmodule

/* test/tb_top.sv */
// Self-checking testbench for the bounded positional list, with a scoreboard that predicts results.
`timescale 1ns / 1ps
module tb_top;
	import pol_pkg::*;

	localparam cmd_code_t CMD_SPARE_FIRST = 3'd5;
	localparam cmd_code_t CMD_SPARE_LAST = 3'd7;
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W - 1){1'b0}}};
	localparam logic signed [VAL_W-1:0] VAL_MAX = ~VAL_MIN;
	localparam int POS_TOP = (1 << POS_W) - 1;
	localparam int RANDOM_ITEMS = 160;
	localparam int IDLE_LIMIT = 2000;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [LEN_W-1:0] pos;
		logic [LEN_W-1:0] len;
		status_t st;
		logic last;
	} list_word_t;

	class list_scoreboard;
		logic signed [VAL_W-1:0] cells[CAPACITY];
		int count = 0;
		list_word_t pending[$];
		int errors = 0;

		task report(string msg);
			$display("ERROR %0t: %s", $time, msg);
			errors++;
		endtask

		function void push_word(logic signed [VAL_W-1:0] v, int p, status_t st, logic l);
			list_word_t w;
			w.value = v;
			w.pos = LEN_W'(p);
			w.len = LEN_W'(count);
			w.st = st;
			w.last = l;
			pending.push_back(w);
		endfunction

		// Applies one accepted command to the shadow list and queues the words it yields.
		function void note_command(cmd_code_t cmd, logic [POS_W-1:0] pos,
				logic signed [VAL_W-1:0] val);
			status_t st;
			bit ins;
			int slot;
			st = ST_OK;
			ins = 1'b0;
			slot = 0;
			case (cmd)
				CMD_INS_FRONT, CMD_INS_BACK: begin
					if (count >= CAPACITY) st = ST_FULL;
					else begin
						ins = 1'b1;
						slot = (cmd == CMD_INS_FRONT) ? 0 : count;
					end
				end
				CMD_INS_AT: begin
					// The range check takes precedence over the full check.
					if (pos == 0 || pos > count + 1) st = ST_RANGE;
					else if (count >= CAPACITY) st = ST_FULL;
					else begin
						ins = 1'b1;
						slot = int'(pos) - 1;
					end
				end
				CMD_DEL_AT: begin
					if (count == 0) st = ST_EMPTY;
					else if (pos == 0 || pos > count) st = ST_RANGE;
					else begin
						for (int i = int'(pos) - 1; i + 1 < count; i++) cells[i] = cells[i + 1];
						count--;
					end
				end
				CMD_DUMP: begin
					if (count == 0) st = ST_EMPTY;
					else begin
						for (int i = 0; i < count; i++)
							push_word(cells[i], i + 1, ST_OK, (i + 1 == count));
						return;
					end
				end
				default: ;
			endcase
			if (ins) begin
				for (int i = count; i > slot; i--) cells[i] = cells[i - 1];
				cells[slot] = val;
				count++;
			end
			push_word('0, 0, st, 1'b1);
		endfunction

		task check_word(list_word_t got);
			list_word_t want;
			if (pending.size() == 0) begin
				report($sformatf("unexpected word value %0d pos %0d len %0d status %0d last %0d",
					got.value, got.pos, got.len, got.st, got.last));
				return;
			end
			want = pending.pop_front();
			if (got.value !== want.value)
				report($sformatf("value_res %0d, expected %0d", got.value, want.value));
			if (got.pos !== want.pos)
				report($sformatf("position_res %0d, expected %0d", got.pos, want.pos));
			if (got.len !== want.len)
				report($sformatf("length %0d, expected %0d", got.len, want.len));
			if (got.st !== want.st)
				report($sformatf("status %0d, expected %0d", got.st, want.st));
			if (got.last !== want.last)
				report($sformatf("last %0d, expected %0d", got.last, want.last));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [CMD_W-1:0] command = '0;
	logic [POS_W-1:0] position = '0;
	logic signed [VAL_W-1:0] value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [VAL_W-1:0] value_res;
	logic [LEN_W-1:0] position_res;
	logic [LEN_W-1:0] length;
	logic [ST_W-1:0] status;
	logic last;

	list_scoreboard sb = new();
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	int rx_phase = 0;
	int stall_left = 0;
	int idle_cycles = 0;
	int items_sent = 0;

	positional_ordered_list uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.position(position),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value_res(value_res),
		.position_res(position_res),
		.length(length),
		.status(status),
		.last(last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Gap before an item: mostly none, sometimes short or medium, rarely a long pause; none in calm mode.
	function automatic int pick_gap(bit calm);
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_command(cmd_code_t cmd, logic [POS_W-1:0] pos,
			logic signed [VAL_W-1:0] val);
		int gap;
		gap = pick_gap(tx_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		position <= pos;
		value <= val;
		do @(posedge clk); while (in_ready !== 1'b1);
		sb.note_command(cmd, pos, val);
		items_sent++;
	endtask

	// Output side back-pressure, in random stretches that are calm or choppy.
	always @(posedge clk) begin
		if (rx_phase == 0) begin
			rx_calm = ($urandom_range(0, 3) == 0);
			rx_phase = $urandom_range(40, 200);
		end
		rx_phase--;
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready <= 1'b1;
			stall_left = pick_gap(rx_calm);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_word('{value_res, position_res, length, status, last});
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int k;
		int reps;
		cmd_code_t c;
		logic [POS_W-1:0] p;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty list, range edges, extremes, spare codes.
		send_command(CMD_DEL_AT, POS_W'(1), '0);
		send_command(CMD_DUMP, '0, '0);
		send_command(CMD_INS_AT, '0, VAL_MAX);
		send_command(CMD_INS_AT, POS_W'(2), VAL_MAX);
		send_command(CMD_INS_AT, POS_W'(1), VAL_MIN);
		send_command(CMD_INS_FRONT, '0, VAL_MAX);
		send_command(CMD_INS_BACK, '1, -1);
		send_command(CMD_INS_AT, POS_W'(4), '0);
		send_command(CMD_INS_AT, '1, VAL_MIN);
		send_command(CMD_DEL_AT, '0, '0);
		send_command(CMD_DEL_AT, POS_W'(5), '0);
		send_command(CMD_DEL_AT, '1, '1);
		for (int s = CMD_SPARE_FIRST; s <= CMD_SPARE_LAST; s++)
			send_command(cmd_code_t'(s), '1, '1);
		send_command(CMD_DUMP, '1, '1);
		send_command(CMD_DEL_AT, POS_W'(2), '0);
		send_command(CMD_DEL_AT, POS_W'(3), '0);
		send_command(CMD_DEL_AT, POS_W'(1), '0);
		send_command(CMD_DUMP, '0, '0);

		reps = items_sent + RANDOM_ITEMS;
		while (items_sent < reps) begin
			tx_calm = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 9))
				0, 1: begin
					// Fill to capacity, then push against the full list and dump it.
					while (sb.count < CAPACITY) begin
						k = $urandom_range(0, 2);
						c = (k == 0) ? CMD_INS_FRONT : (k == 1) ? CMD_INS_BACK : CMD_INS_AT;
						send_command(c, POS_W'($urandom_range(1, sb.count + 1)), $urandom);
					end
					k = $urandom_range(0, 2);
					c = (k == 0) ? CMD_INS_FRONT : (k == 1) ? CMD_INS_BACK : CMD_INS_AT;
					send_command(c, POS_W'($urandom_range(1, CAPACITY + 1)), $urandom);
					send_command(CMD_INS_AT, POS_W'($urandom_range(CAPACITY + 2, POS_TOP)),
						$urandom);
					send_command(CMD_DUMP, POS_W'($urandom), $urandom);
				end
				2: begin
					while (sb.count > 0)
						send_command(CMD_DEL_AT, POS_W'($urandom_range(1, sb.count)), $urandom);
					send_command(CMD_DEL_AT, POS_W'($urandom), $urandom);
					send_command(CMD_DUMP, POS_W'($urandom), $urandom);
				end
				3, 4, 5, 6, 7: begin
					repeat ($urandom_range(4, 12)) begin
						k = $urandom_range(0, 99);
						if (k < 20) c = CMD_INS_FRONT;
						else if (k < 40) c = CMD_INS_BACK;
						else if (k < 65) c = CMD_INS_AT;
						else if (k < 90) c = CMD_DEL_AT;
						else c = CMD_DUMP;
						if ($urandom_range(0, 9) == 0) p = POS_W'($urandom);
						else if (c == CMD_DEL_AT)
							p = POS_W'($urandom_range(1, (sb.count > 0) ? sb.count : 1));
						else p = POS_W'($urandom_range(1, sb.count + 1));
						send_command(c, p, $urandom);
					end
				end
				default: begin
					repeat ($urandom_range(2, 6))
						send_command(CMD_W'($urandom), POS_W'($urandom), $urandom);
				end
			endcase
		end
		in_valid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end
endmodule
